// ===== hdl/r5rd_pkg.sv =====
package r5rd_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CFG_NUM_DISKS = 2'd0;
  localparam logic [1:0] CFG_STRIPE_SIZE = 2'd1;
  localparam logic [1:0] CFG_DISK_DEPTH = 2'd2;

  typedef struct packed {
    logic load_start;
    logic div_start;
    logic div_sel;
    logic div_par;
    logic map_capture;
    logic rd_issue;
    logic acc_clear;
    logic acc_add;
    logic acc_take;
    logic next_disk;
    logic done_ok;
    logic done_nf;
  } r5rd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic geom_bad;
    logic range_bad;
    logic phys_bad;
    logic target_present;
    logic rebuild_ok;
    logic scan_skip;
    logic scan_missing;
    logic scan_last;
  } r5rd_sts_t;

endpackage

// ===== hdl/r5rd_ram.sv =====
module r5rd_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/r5rd_div.sv =====
module r5rd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [13:0] dividend_i,
  input  logic [10:0] divisor_i,
  output logic        done_o,
  output logic [13:0] quot_o,
  output logic [10:0] rem_o
);

  logic [13:0] quot_q, quot_d;
  logic [11:0] rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [10:0] dvs_q, dvs_d;
  logic [12:0] trial;
  logic [11:0] shifted;

  assign shifted = {rem_q[10:0], quot_q[13]};
  assign trial = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    dvs_d = dvs_q;
    done_o = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      cnt_d = 4'd0;
      busy_d = 1'b1;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      if (trial[12]) begin
        rem_d = shifted;
        quot_d = {quot_q[12:0], 1'b0};
      end else begin
        rem_d = trial[11:0];
        quot_d = {quot_q[12:0], 1'b1};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd13) begin
        busy_d = 1'b0;
      end
    end else if (cnt_q == 4'd14) begin
      done_o = 1'b1;
      cnt_d = 4'd15;
    end
  end

  assign quot_o = quot_q;
  assign rem_o = rem_q[10:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 4'd15;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== hdl/r5rd_datapath.sv =====
module r5rd_datapath #(
  parameter int MaxDisks = 8,
  parameter int MaxBlocks = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  r5rd_pkg::r5rd_cmd_t cmd_i,
  output r5rd_pkg::r5rd_sts_t sts_o,
  input  logic [2:0]         disk_number_i,
  input  logic [9:0]         disk_block_i,
  input  logic [31:0]        word_i,
  input  logic [13:0]        logical_block_i,
  input  logic [3:0]         num_disks_i,
  input  logic [10:0]        stripe_size_i,
  input  logic [10:0]        disk_depth_i,
  output logic               found_o,
  output logic [31:0]        value_o
);

  localparam int DW = (MaxDisks > 1) ? $clog2(MaxDisks) : 1;
  localparam int AW = $clog2(MaxDisks * MaxBlocks);

  logic [MaxDisks-1:0] present_q;
  logic [4:0]          loaded_q;
  logic [2:0]          ld_disk_q;
  logic [9:0]          ld_blk_q;
  logic [31:0]         ld_word_q;
  logic [13:0]         lb_q;
  logic [3:0]          n_q;
  logic [10:0]         s_q, bpd_q;
  logic [10:0]         offset_q, idx_q;
  logic [13:0]         strip_q, row_q;
  logic [3:0]          rowmod_q;
  logic [3:0]          disk_q, scan_q;
  logic [20:0]         phys_q;
  logic [31:0]         acc_q;
  logic                found_q;
  logic [31:0]         value_q;

  logic        div_start;
  logic [13:0] div_dvd;
  logic [10:0] div_dvs;
  logic        div_done;
  logic [13:0] div_quot;
  logic [10:0] div_rem;

  logic        load_ok;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rdata;
  logic [3:0]  parity;
  logic [4:0]  dsum;
  logic [3:0]  rd_disk;
  logic [24:0] cap;

  assign div_start = cmd_i.div_start;
  assign div_dvd = cmd_i.div_par ? row_q : (cmd_i.div_sel ? strip_q : lb_q);
  assign div_dvs = cmd_i.div_par ? {7'd0, n_q} :
                   (cmd_i.div_sel ? {7'd0, n_q - 4'd1} : s_q);

  r5rd_div u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign load_ok = ({1'b0, ld_disk_q} < n_q) && (32'(ld_disk_q) < 32'(MaxDisks))
                   && (32'(ld_blk_q) < 32'(MaxBlocks));
  assign we = cmd_i.load_start && load_ok;
  assign waddr = AW'(32'(ld_disk_q) * MaxBlocks + 32'(ld_blk_q));
  assign rd_disk = cmd_i.acc_clear ? disk_q : scan_q;
  assign raddr = AW'(32'(rd_disk) * MaxBlocks + 32'(phys_q));

  r5rd_ram #(.Width(32), .Depth(MaxDisks * MaxBlocks)) u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(ld_word_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // parity disk from row % n, then one wrap of the data disk index
  always_comb begin
    parity = n_q - 4'd1 - rowmod_q;
    dsum = {1'b0, parity} + 5'd1 + 5'(idx_q);
    if (dsum >= {1'b0, n_q}) begin
      dsum = dsum - {1'b0, n_q};
    end
  end

  assign cap = 25'(bpd_q) * 25'(n_q - 4'd1);

  assign sts_o.div_done = div_done;
  assign sts_o.geom_bad = (n_q < 4'd2) || (32'(n_q) > 32'(MaxDisks)) || (s_q == 11'd0)
                          || (bpd_q == 11'd0) || (loaded_q == 5'd0);
  assign sts_o.range_bad = (25'(lb_q) >= cap);
  assign sts_o.phys_bad = (phys_q >= 21'(bpd_q)) || (32'(phys_q) >= 32'(MaxBlocks));
  assign sts_o.target_present = present_q[DW'(disk_q)];
  assign sts_o.rebuild_ok = (loaded_q == 5'(n_q - 4'd1));
  assign sts_o.scan_skip = (scan_q == disk_q);
  assign sts_o.scan_missing = !present_q[DW'(scan_q)];
  assign sts_o.scan_last = (scan_q == n_q - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      loaded_q <= '0;
      found_q <= 1'b0;
      value_q <= '0;
    end else begin
      if (we && !present_q[DW'(ld_disk_q)]) begin
        present_q[DW'(ld_disk_q)] <= 1'b1;
        loaded_q <= loaded_q + 5'd1;
      end
      if (cmd_i.done_ok) begin
        found_q <= 1'b1;
        value_q <= acc_q;
      end else if (cmd_i.done_nf) begin
        found_q <= 1'b0;
        value_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_capture) begin
      ld_disk_q <= disk_number_i;
      ld_blk_q <= disk_block_i;
      ld_word_q <= word_i;
      lb_q <= logical_block_i;
      n_q <= num_disks_i;
      s_q <= stripe_size_i;
      bpd_q <= disk_depth_i;
      scan_q <= '0;
    end
    if (div_done && !cmd_i.div_sel && !cmd_i.div_par) begin
      strip_q <= div_quot;
      offset_q <= div_rem;
    end
    if (div_done && cmd_i.div_sel) begin
      row_q <= div_quot;
      idx_q <= div_rem;
    end
    if (div_done && cmd_i.div_par) begin
      rowmod_q <= div_rem[3:0];
    end
    if (cmd_i.rd_issue) begin
      disk_q <= dsum[3:0];
      phys_q <= 21'(row_q) * 21'(s_q) + 21'(offset_q);
    end
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.acc_take) begin
      acc_q <= rdata;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q ^ rdata;
    end
    if (cmd_i.next_disk) begin
      scan_q <= scan_q + 4'd1;
    end
  end

  assign found_o = found_q;
  assign value_o = value_q;

endmodule

// ===== hdl/r5rd_ctrl.sv =====
module r5rd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                command_i,
  input  r5rd_pkg::r5rd_sts_t sts_i,
  output r5rd_pkg::r5rd_cmd_t cmd_o,
  output logic                busy_o,
  output logic                valid_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_CHK = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_DIV2S = 4'd4;
  localparam logic [3:0] S_DIV2 = 4'd5;
  localparam logic [3:0] S_MAP = 4'd6;
  localparam logic [3:0] S_PCHK = 4'd7;
  localparam logic [3:0] S_RDW = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd10;
  localparam logic [3:0] S_SWAIT = 4'd11;
  localparam logic [3:0] S_SACC = 4'd12;
  localparam logic [3:0] S_OUT = 4'd13;
  localparam logic [3:0] S_DIV3S = 4'd14;
  localparam logic [3:0] S_DIV3 = 4'd15;

  logic [3:0] state_q, state_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.map_capture = 1'b1;
          state_d = (command_i == r5rd_pkg::CMD_LOAD) ? S_LOAD : S_CHK;
        end
      end
      S_LOAD: begin
        cmd_o.load_start = 1'b1;
        state_d = S_IDLE;
      end
      S_CHK: begin
        if (sts_i.geom_bad || sts_i.range_bad) begin
          cmd_o.done_nf = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          state_d = S_DIV2S;
        end
      end
      S_DIV2S: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_DIV3S;
        end
      end
      S_DIV3S: begin
        cmd_o.div_par = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.div_par = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (sts_i.phys_bad) begin
          cmd_o.done_nf = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.target_present) begin
          cmd_o.acc_clear = 1'b1;
          state_d = S_RDW;
        end else if (!sts_i.rebuild_ok) begin
          cmd_o.done_nf = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.acc_clear = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_RDW: begin
        cmd_o.acc_take = 1'b1;
        state_d = S_SACC;
      end
      S_SCAN: begin
        if (sts_i.scan_skip) begin
          if (sts_i.scan_last) begin
            cmd_o.done_ok = 1'b1;
            state_d = S_OUT;
          end else begin
            cmd_o.next_disk = 1'b1;
          end
        end else if (sts_i.scan_missing) begin
          cmd_o.done_nf = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        cmd_o.acc_add = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_SACC;
        end else begin
          cmd_o.next_disk = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SACC: begin
        cmd_o.done_ok = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hdl/raid5_block_read_with_rebuild_unit.sv =====
// raid5 block store with left-symmetric parity mapping and one-disk rebuild
// command channel: an item is taken when start is high and busy is low;
// command_i low loads word_i into disk_number_i/disk_block_i (no result),
// command_i high reads logical_block_i and gives one result
// result: found_o and value_o are shown for one cycle with valid_o high;
// the receiver cannot stall, so a result is never held back
// config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 num_disks, 1 stripe_size,
// 2 disk_depth) and cfg_data_i; ready is always high
// sequence: a load holds busy only for its write state, then the next item can be taken;
// a read of a present disk passes the check, three 14-step shift-subtract
// divisions (strip, row, parity rotation), the mapping and the single read
// port of the block memory before its result is given;
// a read of a missing disk instead scans the other disks, reading and xoring
// each in turn and skipping the missing one, before its result is given;
// a read ruled out by geometry or range answers straight from the check, one
// refused after mapping answers from the physical check
// busy falls in the result cycle; one item is worked on at a time
// reset clears the present mask, loaded count and config to their defaults;
// the block memory is not cleared, stored words are valid once written
module raid5_block_read_with_rebuild_unit #(
  parameter int MaxDisks = 8,
  parameter int MaxBlocks = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [0:0]  command_i,
  input  logic [2:0]  disk_number_i,
  input  logic [9:0]  disk_block_i,
  input  logic [31:0] word_i,
  input  logic [13:0] logical_block_i,
  output logic        valid_o,
  output logic        found_o,
  output logic [31:0] value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [3:0]  num_disks_q;
  logic [10:0] stripe_size_q;
  logic [10:0] disk_depth_q;
  r5rd_pkg::r5rd_cmd_t cmd;
  r5rd_pkg::r5rd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_disks_q <= 4'd3;
      stripe_size_q <= 11'd1;
      disk_depth_q <= 11'd1024;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        r5rd_pkg::CFG_NUM_DISKS: num_disks_q <= cfg_data_i[3:0];
        r5rd_pkg::CFG_STRIPE_SIZE: stripe_size_q <= cfg_data_i[10:0];
        r5rd_pkg::CFG_DISK_DEPTH: disk_depth_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  r5rd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i  (start),
    .command_i(command_i[0]),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .valid_o  (valid_o)
  );

  r5rd_datapath #(.MaxDisks(MaxDisks), .MaxBlocks(MaxBlocks)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .disk_number_i    (disk_number_i),
    .disk_block_i     (disk_block_i),
    .word_i           (word_i),
    .logical_block_i  (logical_block_i),
    .num_disks_i      (num_disks_q),
    .stripe_size_i    (stripe_size_q),
    .disk_depth_i     (disk_depth_q),
    .found_o          (found_o),
    .value_o          (value_o)
  );

endmodule
